### hw/rtl/uv_sphere_quad_vertex_generator_defines.svh
// ----------------------------------------------------------------------------
// UV sphere quad vertex generator assertion macros
// Shared concurrent assertion forms for the vertex generator.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_QUAD_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_QUAD_VERTEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define UVSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define UVSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/uvsq_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere quad vertex generator package
// Types, constants and arithmetic helpers for the vertex pipeline.
// ----------------------------------------------------------------------------
package uvsq_pkg;

  // Configuration register indexes
  localparam logic CFG_SEGMENTS = 1'b0;
  localparam logic CFG_RADIUS   = 1'b1;

  localparam logic [8:0] SEG_MAX   = 9'd256;
  localparam logic [8:0] SEG_RESET = 9'd16;
  localparam logic [15:0] RADIUS_RESET = 16'd256;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  // Long division: five quotient bits per stage, 25-bit dividend
  localparam int DIV_STAGES = 5;

  // Sine polynomial coefficients, Q30
  localparam logic [30:0] Q30_A = 31'd1686629713;
  localparam logic [29:0] Q30_B = 30'd688904866;
  localparam logic [26:0] Q30_C = 27'd76016977;

  typedef struct packed {
    logic [24:0] num;
    logic [8:0]  rem;
    logic [24:0] quo;
  } div_t;

  typedef struct packed {
    logic [17:0] idx;
    logic        last;
  } tag_t;

  typedef struct packed {
    logic [17:0] idx;
    logic        last;
    logic [16:0] texu;
    logic [16:0] texv;
  } carry_t;

  // Five restoring division steps; b holds the next dividend bits, MSB first
  function automatic div_t div_step5(div_t d, logic [4:0] b, logic [8:0] s);
    logic [9:0]  rem;
    logic [24:0] quo;
    div_t        o;
    rem = {1'b0, d.rem};
    quo = d.quo;
    for (int i = 4; i >= 0; i--) begin
      rem = {rem[8:0], b[i]};
      if (rem >= {1'b0, s}) begin
        rem = rem - {1'b0, s};
        quo = {quo[23:0], 1'b1};
      end else begin
        quo = {quo[23:0], 1'b0};
      end
    end
    o.num = d.num;
    o.rem = rem[8:0];
    o.quo = quo;
    return o;
  endfunction

  // Saturate a quotient to 1.0 in Q1.16
  function automatic logic [16:0] sat_q16(logic [24:0] q);
    return (q > 25'd65536) ? 17'd65536 : q[16:0];
  endfunction

  // Shift right by n, rounding halves away from zero
  function automatic logic signed [63:0] round_shift(logic signed [63:0] v,
                                                     logic [4:0] n);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (n - 5'd1))) >> n;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

### hw/rtl/uv_sphere_quad_vertex_generator.sv
// ----------------------------------------------------------------------------
// UV sphere quad vertex generator
// Emits the four corner vertices of one UV sphere quad per command.
// ----------------------------------------------------------------------------
// A command (start while busy is low) names one quad by ring and column. The
// block answers with four vertices on consecutive cycles, each marked by
// out_valid for one cycle; out_last flags the fourth. The receiver cannot
// stall. A new command can be taken while the last corner of the previous one
// is issued: the corner sequencer issues one corner per cycle into a 13-stage
// pipeline (a dividend load stage, five long-division stages for the angle
// phases, four sine polynomial stages, three product and rounding stages).
// Write configuration only while no vertex is in flight.
`include "uv_sphere_quad_vertex_generator_defines.svh"

module uv_sphere_quad_vertex_generator
  import uvsq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_ring,
  input  logic [7:0]         in_column,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic [17:0]        out_vertex_index,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic signed [16:0] out_tan_x,
  output logic signed [16:0] out_tan_z,
  output logic               out_last
);

  // Configuration registers
  logic [8:0]  segments_r;
  logic [15:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segments_r <= SEG_RESET;
      radius_r   <= RADIUS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SEGMENTS) segments_r <= cfg_wdata[8:0];
      else                           radius_r   <= cfg_wdata;
    end
  end

  // Effective segment count and its half
  logic [8:0] seg_s;
  logic [7:0] seg_half;
  logic signed [16:0] rad_s;

  assign seg_s    = (segments_r == 9'd0) ? 9'd1 :
                    (segments_r > SEG_MAX) ? SEG_MAX : segments_r;
  assign seg_half = seg_s[8:1];
  assign rad_s    = $signed({1'b0, radius_r});

  // Corner sequencer
  logic       act_r, act_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] ring_r, col_r;
  logic       accept;

  assign busy   = act_r && (cnt_r != CORNER_LAST);
  assign accept = start && !busy;

  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      act_nxt = 1'b1;
      cnt_nxt = 2'd0;
    end else if (act_r) begin
      if (cnt_r == CORNER_LAST) act_nxt = 1'b0;
      else                      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring_r <= in_ring;
      col_r  <= in_column;
    end
  end

  // Corner coordinates and dividends
  logic [8:0]  col_k, ring_k;
  logic [16:0] base_prod;
  logic [17:0] idx_k;

  assign col_k     = {1'b0, col_r} + ((cnt_r == 2'd1 || cnt_r == 2'd2) ? 9'd1 : 9'd0);
  assign ring_k    = {1'b0, ring_r} + ((cnt_r == 2'd0 || cnt_r == 2'd1) ? 9'd1 : 9'd0);
  assign base_prod = ({9'd0, ring_r} * {8'd0, seg_s}) + {9'd0, col_r};
  assign idx_k     = {base_prod[15:0], cnt_r};

  // Division pipeline: column phase, ring texture and ring phase
  logic [DIV_STAGES:0] dv_r;
  tag_t                dt_r [DIV_STAGES+1];
  div_t                dc_r [DIV_STAGES+1];
  div_t                dr_r [DIV_STAGES+1];
  div_t                dd_r [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else        dv_r <= {dv_r[DIV_STAGES-1:0], act_r};
  end

  // Load dividends
  always_ff @(posedge clk) begin
    dt_r[0].idx  <= idx_k;
    dt_r[0].last <= (cnt_r == CORNER_LAST);
    dc_r[0]      <= '{num: {col_k, 8'd0, seg_half}, rem: 9'd0, quo: 25'd0};
    dr_r[0]      <= '{num: {ring_k, 8'd0, seg_half}, rem: 9'd0, quo: 25'd0};
    dd_r[0]      <= '{num: {1'b0, ring_k, 7'd0, seg_half}, rem: 9'd0, quo: 25'd0};
  end

  // Advance five quotient bits per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      dt_r[k+1] <= dt_r[k];
      dc_r[k+1] <= div_step5(dc_r[k], dc_r[k].num[24-5*k -: 5], seg_s);
      dr_r[k+1] <= div_step5(dr_r[k], dr_r[k].num[24-5*k -: 5], seg_s);
      dd_r[k+1] <= div_step5(dd_r[k], dd_r[k].num[24-5*k -: 5], seg_s);
    end
  end

  // Phases: lane 0 sin theta, 1 cos theta, 2 sin delta, 3 cos delta
  logic [15:0] ph [4];
  assign ph[0] = dc_r[DIV_STAGES].quo[15:0];
  assign ph[1] = dc_r[DIV_STAGES].quo[15:0] + 16'd16384;
  assign ph[2] = dd_r[DIV_STAGES].quo[15:0];
  assign ph[3] = dd_r[DIV_STAGES].quo[15:0] + 16'd16384;

  // Carry tags through sine and product stages
  logic [5:0] sv_r;
  carry_t     cs_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= '0;
    else        sv_r <= {sv_r[4:0], dv_r[DIV_STAGES]};
  end

  always_ff @(posedge clk) begin
    cs_r[0].idx  <= dt_r[DIV_STAGES].idx;
    cs_r[0].last <= dt_r[DIV_STAGES].last;
    cs_r[0].texu <= sat_q16(dc_r[DIV_STAGES].quo);
    cs_r[0].texv <= sat_q16(dr_r[DIV_STAGES].quo);
    for (int i = 1; i < 6; i++) cs_r[i] <= cs_r[i-1];
  end

  // Sine stage A: fold to a quarter wave, square
  logic [14:0] za_r [4];
  logic [30:0] z2a_r [4];
  logic        nga_r [4];
  logic [14:0] zf [4];
  logic [29:0] zsq [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      zf[l]  = ph[l][14] ? 15'(15'd16384 - {1'b0, ph[l][13:0]}) : {1'b0, ph[l][13:0]};
      zsq[l] = {15'd0, zf[l]} * {15'd0, zf[l]};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      za_r[l]  <= zf[l];
      z2a_r[l] <= 31'({zsq[l], 2'b00});
      nga_r[l] <= ph[l][15];
    end
  end

  // Sine stage B: inner term
  logic [14:0] zb_r [4];
  logic [30:0] z2b_r [4];
  logic [29:0] inb_r [4];
  logic        ngb_r [4];
  logic [57:0] pb [4];

  always_comb begin
    for (int l = 0; l < 4; l++) pb[l] = 58'(z2a_r[l]) * 58'(Q30_C);
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      zb_r[l]  <= za_r[l];
      z2b_r[l] <= z2a_r[l];
      inb_r[l] <= Q30_B - 30'(pb[l][57:30]);
      ngb_r[l] <= nga_r[l];
    end
  end

  // Sine stage C: middle term
  logic [14:0] zc_r [4];
  logic [30:0] mdc_r [4];
  logic        ngc_r [4];
  logic [60:0] pc [4];

  always_comb begin
    for (int l = 0; l < 4; l++) pc[l] = 61'(z2b_r[l]) * 61'(inb_r[l]);
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      zc_r[l]  <= zb_r[l];
      mdc_r[l] <= Q30_A - pc[l][60:30];
      ngc_r[l] <= ngb_r[l];
    end
  end

  // Sine stage D: final product, clamp, round to Q1.14, sign
  logic signed [15:0] trig_r [4];
  logic [45:0] pd [4];
  logic [31:0] sq [4];
  logic [15:0] sr [4];
  logic [15:0] sm [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      pd[l] = 46'(zc_r[l]) * 46'(mdc_r[l]);
      sq[l] = pd[l][45:14];
      if (sq[l] > 32'h4000_0000) sq[l] = 32'h4000_0000;
      sr[l] = 16'((sq[l] + 32'd32768) >> 16);
      sm[l] = (sr[l] > 16'd16384) ? 16'd16384 : sr[l];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) trig_r[l] <= ngc_r[l] ? -$signed(sm[l]) : $signed(sm[l]);
  end

  // Product stage E: trig products and radius times cos delta
  logic signed [31:0] ctsd_e_r, stsd_e_r, stcd_e_r;
  logic signed [32:0] rcd_e_r;
  logic signed [15:0] cd_e_r;

  always_ff @(posedge clk) begin
    ctsd_e_r <= 32'(trig_r[1]) * 32'(trig_r[2]);
    stsd_e_r <= 32'(trig_r[0]) * 32'(trig_r[2]);
    stcd_e_r <= 32'(trig_r[0]) * 32'(trig_r[3]);
    rcd_e_r  <= 33'(rad_s) * 33'(trig_r[3]);
    cd_e_r   <= trig_r[3];
  end

  // Product stage F: scale by radius
  logic signed [48:0] px_f_r, pz_f_r, tz_f_r;
  logic signed [31:0] ctsd_f_r, stsd_f_r;
  logic signed [32:0] rcd_f_r;
  logic signed [15:0] cd_f_r;

  always_ff @(posedge clk) begin
    px_f_r   <= 49'(rad_s) * 49'(ctsd_e_r);
    pz_f_r   <= 49'(rad_s) * 49'(stsd_e_r);
    tz_f_r   <= 49'(rad_s) * 49'(stcd_e_r);
    ctsd_f_r <= ctsd_e_r;
    stsd_f_r <= stsd_e_r;
    rcd_f_r  <= rcd_e_r;
    cd_f_r   <= cd_e_r;
  end

  // Output stage: round and register
  logic               out_valid_r;
  logic [17:0]        out_idx_r;
  logic signed [16:0] out_px_r, out_py_r, out_pz_r, out_tx_r, out_tz_r;
  logic signed [15:0] out_nx_r, out_ny_r, out_nz_r;
  logic [16:0]        out_tu_r, out_tv_r;
  logic               out_last_r;
  logic signed [63:0] pz_rnd;

  assign pz_rnd = round_shift(64'(pz_f_r), 5'd28);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= sv_r[5];
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= cs_r[5].idx;
    out_last_r <= cs_r[5].last;
    out_tu_r   <= cs_r[5].texu;
    out_tv_r   <= cs_r[5].texv;
    out_px_r   <= 17'(round_shift(64'(px_f_r), 5'd28));
    out_py_r   <= 17'(round_shift(64'(rcd_f_r), 5'd14));
    out_pz_r   <= 17'(pz_rnd);
    out_nx_r   <= 16'(round_shift(64'(ctsd_f_r), 5'd14));
    out_ny_r   <= cd_f_r;
    out_nz_r   <= 16'(round_shift(64'(stsd_f_r), 5'd14));
    out_tx_r   <= 17'(-pz_rnd);
    out_tz_r   <= 17'(round_shift(64'(tz_f_r), 5'd28));
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_pos_x        = out_px_r;
  assign out_pos_y        = out_py_r;
  assign out_pos_z        = out_pz_r;
  assign out_norm_x       = out_nx_r;
  assign out_norm_y       = out_ny_r;
  assign out_norm_z       = out_nz_r;
  assign out_tex_u        = out_tu_r;
  assign out_tex_v        = out_tv_r;
  assign out_tan_x        = out_tx_r;
  assign out_tan_z        = out_tz_r;
  assign out_last         = out_last_r;

  // Checks
  `UVSQ_ASSERT_NOW(a_accept_gap, clk, rst_n, accept, !act_r || cnt_r == CORNER_LAST, "item accepted mid-quad")
  `UVSQ_ASSERT_NEXT(a_quad_burst, clk, rst_n, out_valid && !out_last, out_valid, "vertex burst broken")
  `UVSQ_ASSERT_NOW(a_last_corner, clk, rst_n, out_valid, out_last == (out_vertex_index[1:0] == CORNER_LAST), "last flag off corner")

endmodule
